// ----- rtl/wedm_pkg.sv -----
`timescale 1ns / 1ps

package wedm_pkg;

    // widths fixed by the field and register definitions
    localparam int LEVEL_W    = 8;
    localparam int POS_W      = 11;
    localparam int SIZE_W     = 12;
    localparam int THRESH_W   = 8;
    localparam int LIMIT_W    = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    // positions never reach this, sizes are clamped to it
    localparam int POS_LIMIT = 2048;

    // reset values of the configuration registers
    localparam logic [SIZE_W-1:0]   WIDTH_RESET     = 12'd640;
    localparam logic [SIZE_W-1:0]   HEIGHT_RESET    = 12'd480;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd45;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = 6'd9;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2,
        CFG_COUNT_LIMIT    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

endpackage

// ----- rtl/wedm_position.sv -----
`timescale 1ns / 1ps

module wedm_position #(
    parameter int W_LIM = 2048,
    parameter int H_LIM = 2048
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [wedm_pkg::SIZE_W-1:0] frame_width,
    input  logic [wedm_pkg::SIZE_W-1:0] frame_height,
    input  logic                        frame_start,
    input  logic                        step,
    output wedm_pkg::pos_t              pos
);
    import wedm_pkg::*;

    localparam logic [SIZE_W-1:0] W_MAX = SIZE_W'(W_LIM);
    localparam logic [SIZE_W-1:0] H_MAX = SIZE_W'(H_LIM);

    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] ew, eh;
    logic [SIZE_W-1:0] col0, row0, col1, row1, row2, cn, rn;

    // clamp sizes to the usable range
    always_comb
    begin
        if (frame_width == '0)
            ew = SIZE_W'(1);
        else if (frame_width > W_MAX)
            ew = W_MAX;
        else
            ew = frame_width;
        if (frame_height == '0)
            eh = SIZE_W'(1);
        else if (frame_height > H_MAX)
            eh = H_MAX;
        else
            eh = frame_height;
    end

    always_comb
    begin
        col0 = frame_start ? '0 : {1'b0, col_reg};
        row0 = frame_start ? '0 : {1'b0, row_reg};
        if (col0 >= ew)
        begin
            col1 = '0;
            row1 = row0 + SIZE_W'(1);
        end
        else
        begin
            col1 = col0;
            row1 = row0;
        end
        row2 = (row1 >= eh) ? '0 : row1;

        cn = col1 + SIZE_W'(1);
        rn = row2;
        if (cn >= ew)
        begin
            cn = '0;
            rn = row2 + SIZE_W'(1);
            if (rn >= eh)
                rn = '0;
        end
        col_next = cn[POS_W-1:0];
        row_next = rn[POS_W-1:0];
    end

    assign pos = {row2[POS_W-1:0], col1[POS_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- rtl/wedm_line_store.sv -----
`timescale 1ns / 1ps

module wedm_line_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] byp_data_reg;
    logic              byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rdata_reg    <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // same column written while being read: take the new bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_reg <= 1'b0;
        else if (adv)
            byp_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = byp_reg ? byp_data_reg : rdata_reg;

endmodule

// ----- rtl/wedm_window.sv -----
`timescale 1ns / 1ps

module wedm_window #(
    parameter int WINDOW_MARGIN = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [2*WINDOW_MARGIN:0]     vec,
    input  logic [wedm_pkg::LIMIT_W-1:0] count_limit,
    output logic                         dense
);
    import wedm_pkg::*;

    localparam int SPAN  = 2 * WINDOW_MARGIN + 1;
    localparam int CNT_W = $clog2(SPAN + 1);
    localparam int SUM_W = $clog2(SPAN * SPAN + 1);
    localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    logic [SPAN-1:0]  win_reg [SPAN];
    logic [CNT_W-1:0] cnt_reg [SPAN];
    logic [CNT_W-1:0] vec_cnt;
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] count;

    always_comb
    begin
        vec_cnt = '0;
        for (int i = 0; i < SPAN; i++)
            vec_cnt = vec_cnt + CNT_W'(vec[i]);
    end

    // column counts kept alongside the bit columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SPAN; k++)
            begin
                win_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end
        else if (shift_en)
        begin
            win_reg[0] <= vec;
            cnt_reg[0] <= vec_cnt;
            for (int k = 1; k < SPAN; k++)
            begin
                win_reg[k] <= win_reg[k-1];
                cnt_reg[k] <= cnt_reg[k-1];
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int k = 0; k < SPAN; k++)
            total = total + SUM_W'(cnt_reg[k]);
        count = total - SUM_W'(win_reg[WINDOW_MARGIN][WINDOW_MARGIN]);
        dense = CMP_W'(count) > CMP_W'(count_limit);
    end

endmodule

// ----- rtl/window_edge_density_map.sv -----
`timescale 1ns / 1ps

// channel   | handshake                   | payload
// ----------+-----------------------------+------------------------------------------
// s_axis    | s_axis_tvalid/s_axis_tready | tdata: edge_level; tuser: frame_start
// m_axis    | m_axis_tvalid/m_axis_tready | tdata: centre_column, centre_row, dense
// cfg       | cfg_wr_en                   | cfg_addr, cfg_wr_data
//
// one item per clock sustained unless a held result stalls the pipe; an accepted
// item passes through the input register, the registered line store read, the window
// count stage and the result register
// reset clears positions, window columns, valid flags; the line store is not cleared
// a held result stalls the pipe only when the next result is ready behind it

module window_edge_density_map #(
    parameter int MAX_WIDTH     = 2048,
    parameter int MAX_HEIGHT    = 2048,
    parameter int WINDOW_MARGIN = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [wedm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wedm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] edge_level
    input  logic [0:0]                      s_axis_tuser,   // [0] frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata    // [10:0] centre_column,
                                                            // [21:11] centre_row,
                                                            // [22] dense, [23] zero
);
    import wedm_pkg::*;

    localparam int SPAN   = 2 * WINDOW_MARGIN + 1;
    localparam int HIST_W = 2 * WINDOW_MARGIN;
    localparam int W_LIM  = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
    localparam int H_LIM  = (MAX_HEIGHT < POS_LIMIT) ? MAX_HEIGHT : POS_LIMIT;
    localparam int ADDR_W = $clog2(W_LIM);
    localparam logic [POS_W-1:0] EDGE_OFS = POS_W'(HIST_W);
    localparam logic [POS_W-1:0] MARGIN   = POS_W'(WINDOW_MARGIN);

    // configuration registers
    logic [SIZE_W-1:0]   frame_width_reg;
    logic [SIZE_W-1:0]   frame_height_reg;
    logic [THRESH_W-1:0] edge_threshold_reg;
    logic [LIMIT_W-1:0]  count_limit_reg;

    // input stage
    logic               a_valid_reg;
    logic [LEVEL_W-1:0] a_level_reg;
    logic               a_start_reg;
    pos_t               a_pos;
    logic               a_edge;

    // line store read stage
    logic              b_valid_reg;
    pos_t              b_pos_reg;
    logic              b_edge_reg;
    logic [HIST_W-1:0] b_hist;
    logic [SPAN-1:0]   b_vec;
    logic              b_emit;

    // count stage
    logic             c_emit_reg;
    logic [POS_W-1:0] c_col_reg;
    logic [POS_W-1:0] c_row_reg;
    logic             c_dense;

    // result register
    logic             m_valid_reg;
    logic [POS_W-1:0] m_col_reg;
    logic [POS_W-1:0] m_row_reg;
    logic             m_dense_reg;

    logic adv;

    // the whole pipe moves unless a finished result is blocked behind a held one
    assign adv           = !(c_emit_reg && m_valid_reg && !m_axis_tready);
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= WIDTH_RESET;
            frame_height_reg   <= HEIGHT_RESET;
            edge_threshold_reg <= THRESHOLD_RESET;
            count_limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_wr_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wr_data[SIZE_W-1:0];
                CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_wr_data[THRESH_W-1:0];
                CFG_COUNT_LIMIT:    count_limit_reg    <= cfg_wr_data[LIMIT_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_level_reg <= s_axis_tdata[LEVEL_W-1:0];
            a_start_reg <= s_axis_tuser[0];
        end
    end

    // raster position of the item in the input register
    wedm_position #(
        .W_LIM (W_LIM),
        .H_LIM (H_LIM)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .frame_start  (a_start_reg),
        .step         (adv && a_valid_reg),
        .pos          (a_pos)
    );

    assign a_edge = a_level_reg > edge_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_pos_reg  <= a_pos;
            b_edge_reg <= a_edge;
        end
    end

    // edge bits of the rows above, one word per column
    wedm_line_store #(
        .DEPTH  (W_LIM),
        .ADDR_W (ADDR_W),
        .DATA_W (HIST_W)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .rd_addr (a_pos.col[ADDR_W-1:0]),
        .wr_en   (adv && b_valid_reg),
        .wr_addr (b_pos_reg.col[ADDR_W-1:0]),
        .wr_data (b_vec[HIST_W-1:0]),
        .rd_data (b_hist)
    );

    // bit column of this pixel, newest row in bit 0
    assign b_vec  = {b_hist, b_edge_reg};
    assign b_emit = b_valid_reg && (b_pos_reg.col >= EDGE_OFS) && (b_pos_reg.row >= EDGE_OFS);

    wedm_window #(
        .WINDOW_MARGIN (WINDOW_MARGIN)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (adv && b_valid_reg),
        .vec         (b_vec),
        .count_limit (count_limit_reg),
        .dense       (c_dense)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_emit_reg <= 1'b0;
        else if (adv)
            c_emit_reg <= b_emit;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_col_reg <= b_pos_reg.col - MARGIN;
            c_row_reg <= b_pos_reg.row - MARGIN;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv && c_emit_reg)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && c_emit_reg)
        begin
            m_col_reg   <= c_col_reg;
            m_row_reg   <= c_row_reg;
            m_dense_reg <= c_dense;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_dense_reg, m_row_reg, m_col_reg};

endmodule

// ----- rtl/wedm_checker.sv -----
`timescale 1ns / 1ps

module wedm_checker #(
    parameter int WINDOW_MARGIN = 3
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    localparam logic [10:0] MARGIN = 11'(WINDOW_MARGIN);

    // a held result keeps its value
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while held");

    // nothing waiting at the output, so the input side must be open
    a_open : assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input closed with empty result register");

    // every centre lies at least the margin from the top and left frame edges
    a_inner : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:0] >= MARGIN) && (m_axis_tdata[21:11] >= MARGIN))
        else $error("centre closer to frame edge than margin");

    // padding bit stays clear
    a_pad : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[23])
        else $error("padding bit set");

endmodule

bind window_edge_density_map wedm_checker #(
    .WINDOW_MARGIN (WINDOW_MARGIN)
) u_wedm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
